// ===== rtl/smms_pkg.sv =====
// shared types, constants and codes for the min/max/sum stack
`default_nettype none

package smms_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 5;

    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] min_value;
        logic signed [DATA_W-1:0] max_value;
        logic signed [DATA_W-1:0] sum_value;
        logic                     is_empty;
        logic                     is_full;
        logic                     ignored;
    } out_item_t;

    // one stack slot with the extremes of everything at or below it
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] pmin;
        logic signed [DATA_W-1:0] pmax;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP_LAST,
        S_POP_READ,
        S_POP_LOAD,
        S_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic ignore;
        logic push;
        logic pop_last;
        logic pop_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic empty;
        logic one_left;
        logic full;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/stack_with_min_max_sum.sv =====
// top level of the bounded stack with running min, max and sum
//
// usage:
//   request channel: drive request and raise start; the item is taken at a
//   clock edge where start is high and busy is low. func selects push or pop.
//   result channel: done is high for exactly one cycle with result valid;
//   the receiver cannot stall it and must take it in that cycle.
// sequencing:
//   ignored item: S_IDLE, then S_RESP, where the result is shown
//   push, pop of the last entry: S_PUSH or S_POP_LAST, then S_RESP
//   other pops: S_POP_READ (for the registered ram read), S_POP_LOAD, S_RESP
//   one item at a time; busy stays high until the result cycle ends, so a
//   new item is taken only once the result of the last one is out.
//   each ram slot holds the value plus min and max of the slots below it,
//   so a pop never rescans the stack.
// reset:
//   rst_n low empties the stack: count 0, min 2147483647, max -2147483648,
//   sum 0, top 0. ram contents need no clearing.
`default_nettype none

module stack_with_min_max_sum
    import smms_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire in_item_t request,
    output logic          busy,
    output logic          done,
    output out_item_t     result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    smms_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (request.func),
        .status (status),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    smms_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (request.value),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.is_empty |->
            result.min_value == INT_MAX && result.max_value == INT_MIN &&
            result.sum_value == '0 && result.top_value == '0)
        else $error("empty stack reports non-empty aggregates");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.is_empty |-> result.min_value <= result.max_value)
        else $error("min above max on non-empty stack");

    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.is_empty |->
            result.top_value >= result.min_value && result.top_value <= result.max_value)
        else $error("top entry outside min/max range");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not start work");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.is_empty && result.is_full))
        else $error("stack reported both empty and full");

endmodule

`default_nettype wire

// ===== rtl/smms_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none

module smms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/smms_ctrl.sv =====
// controller state machine for the min/max/sum stack
`default_nettype none

module smms_ctrl
    import smms_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       func,
    input  wire dp_status_t status,
    output logic            busy,
    output logic            done,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   drop;

    assign drop = ((func == FUNC_PUSH) && status.full) ||
                  ((func == FUNC_POP) && status.empty);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (drop)
                    begin
                        state_next = S_RESP;
                    end
                    else if (func == FUNC_PUSH)
                    begin
                        state_next = S_PUSH;
                    end
                    else if (status.one_left)
                    begin
                        state_next = S_POP_LAST;
                    end
                    else
                    begin
                        state_next = S_POP_READ;
                    end
                end
            end
            S_PUSH:     state_next = S_RESP;
            S_POP_LAST: state_next = S_RESP;
            S_POP_READ: state_next = S_POP_LOAD;
            S_POP_LOAD: state_next = S_RESP;
            S_RESP:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
                cmd.ignore  = drop;
            end
            S_PUSH:     cmd.push     = 1'b1;
            S_POP_LAST: cmd.pop_last = 1'b1;
            S_POP_READ: busy         = 1'b1;
            S_POP_LOAD: cmd.pop_load = 1'b1;
            S_RESP:     done         = 1'b1;
            default:    busy         = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/smms_dp.sv =====
// datapath: entry ram, level counter and running aggregates
`default_nettype none

module smms_dp
    import smms_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire ctrl_cmd_t cmd,
    output dp_status_t     status,
    output out_item_t      result
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [LW-1:0]            level_reg;
    logic signed [DATA_W-1:0] top_reg;
    logic signed [DATA_W-1:0] min_reg;
    logic signed [DATA_W-1:0] max_reg;
    logic signed [DATA_W-1:0] sum_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic                     ignored_reg;

    logic signed [DATA_W-1:0] push_min;
    logic signed [DATA_W-1:0] push_max;
    entry_t                   wr_entry;
    entry_t                   rd_entry;
    logic [$bits(entry_t)-1:0] rd_bits;
    logic [AW-1:0]            waddr;
    logic [AW-1:0]            raddr;

    always_comb
    begin
        if (level_reg == '0)
        begin
            push_min = value_reg;
            push_max = value_reg;
        end
        else
        begin
            push_min = (value_reg < min_reg) ? value_reg : min_reg;
            push_max = (value_reg > max_reg) ? value_reg : max_reg;
        end
    end

    assign wr_entry = '{value: value_reg, pmin: push_min, pmax: push_max};
    assign waddr    = AW'(level_reg);
    assign raddr    = AW'(level_reg - LW'(2));
    assign rd_entry = entry_t'(rd_bits);

    smms_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (waddr),
        .wdata (wr_entry),
        .raddr (raddr),
        .rdata (rd_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= '0;
            top_reg     <= '0;
            min_reg     <= INT_MAX;
            max_reg     <= INT_MIN;
            sum_reg     <= '0;
            ignored_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                ignored_reg <= cmd.ignore;
            end
            if (cmd.push)
            begin
                level_reg <= level_reg + LW'(1);
                top_reg   <= value_reg;
                min_reg   <= push_min;
                max_reg   <= push_max;
                sum_reg   <= (level_reg == '0) ? value_reg : sum_reg + value_reg;
            end
            if (cmd.pop_last)
            begin
                level_reg <= '0;
                top_reg   <= '0;
                min_reg   <= INT_MAX;
                max_reg   <= INT_MIN;
                sum_reg   <= '0;
            end
            if (cmd.pop_load)
            begin
                level_reg <= level_reg - LW'(1);
                top_reg   <= rd_entry.value;
                min_reg   <= rd_entry.pmin;
                max_reg   <= rd_entry.pmax;
                sum_reg   <= sum_reg - top_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg <= value;
        end
    end

    assign status.empty    = (level_reg == '0);
    assign status.one_left = (level_reg == LW'(1));
    assign status.full     = (level_reg == LW'(DEPTH));

    assign result.top_value = top_reg;
    assign result.count     = COUNT_W'(level_reg);
    assign result.min_value = min_reg;
    assign result.max_value = max_reg;
    assign result.sum_value = sum_reg;
    assign result.is_empty  = status.empty;
    assign result.is_full   = status.full;
    assign result.ignored   = ignored_reg;

endmodule

`default_nettype wire

// ===== tb/tb_stack_with_min_max_sum.sv =====
// self-checking testbench for the min/max/sum stack: directed and random push/pop items
module tb_stack_with_min_max_sum;
    timeunit 1ns;
    timeprecision 1ps;

    import smms_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  request = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    logic signed [DATA_W-1:0] model_slots [STACK_DEPTH];
    int unsigned              model_level;
    logic signed [DATA_W-1:0] model_min;
    logic signed [DATA_W-1:0] model_max;
    logic signed [DATA_W-1:0] model_sum;

    out_item_t expected_q [$];
    int        err_cnt = 0;
    int        cycle_cnt = 0;
    int        idle_pct = 0;

    stack_with_min_max_sum #(.DEPTH(STACK_DEPTH)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("stack_with_min_max_sum verification failed");
            $finish;
        end
    end

    function automatic out_item_t apply_stack_op(input in_item_t it);
        out_item_t            res;
        logic signed [DATA_W-1:0] removed;
        res = '0;
        if (it.func == FUNC_PUSH)
        begin
            if (model_level >= STACK_DEPTH)
                res.ignored = 1'b1;
            else
            begin
                model_slots[model_level] = it.value;
                if (model_level == 0)
                begin
                    model_min = it.value;
                    model_max = it.value;
                    model_sum = it.value;
                end
                else
                begin
                    if (it.value < model_min)
                        model_min = it.value;
                    if (it.value > model_max)
                        model_max = it.value;
                    model_sum = model_sum + it.value;
                end
                model_level++;
            end
        end
        else
        begin
            if (model_level == 0)
                res.ignored = 1'b1;
            else
            begin
                model_level--;
                removed = model_slots[model_level];
                if (model_level == 0)
                begin
                    model_min = INT_MAX;
                    model_max = INT_MIN;
                    model_sum = '0;
                end
                else
                begin
                    model_sum = model_sum - removed;
                    if (removed == model_min || removed == model_max)
                    begin
                        model_min = INT_MAX;
                        model_max = INT_MIN;
                        for (int i = 0; i < model_level; i++)
                        begin
                            if (model_slots[i] < model_min)
                                model_min = model_slots[i];
                            if (model_slots[i] > model_max)
                                model_max = model_slots[i];
                        end
                    end
                end
            end
        end
        res.top_value = (model_level > 0) ? model_slots[model_level-1] : '0;
        res.count     = model_level[COUNT_W-1:0];
        res.min_value = model_min;
        res.max_value = model_max;
        res.sum_value = model_sum;
        res.is_empty  = (model_level == 0);
        res.is_full   = (model_level == STACK_DEPTH);
        return res;
    endfunction

    always @(posedge clk)
    begin
        out_item_t exp_item;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result at cycle %0d: %p", cycle_cnt, result);
            end
            else
            begin
                exp_item = expected_q.pop_front();
                if (result.top_value !== exp_item.top_value
                    || result.count !== exp_item.count
                    || result.min_value !== exp_item.min_value
                    || result.max_value !== exp_item.max_value
                    || result.sum_value !== exp_item.sum_value
                    || result.is_empty !== exp_item.is_empty
                    || result.is_full !== exp_item.is_full
                    || result.ignored !== exp_item.ignored)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                    begin
                        $display("mismatch at cycle %0d", cycle_cnt);
                        $display("  expected %p", exp_item);
                        $display("  actual   %p", result);
                    end
                end
            end
        end
    end

    task automatic send_item(input logic func, input logic signed [DATA_W-1:0] value);
        in_item_t it;
        it.func  = func;
        it.value = value;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start   <= 1'b1;
        request <= it;
        do
            @(posedge clk);
        while (busy);
        expected_q.push_back(apply_stack_op(it));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return INT_MIN;
            1: return INT_MAX;
            2, 3, 4: return int'($urandom_range(16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_edges();
        idle_pct = 9;
        send_item(FUNC_POP, INT_MAX);
        send_item(FUNC_PUSH, INT_MIN);
        send_item(FUNC_PUSH, INT_MAX);
        send_item(FUNC_POP, '0);
        send_item(FUNC_PUSH, -1);
        send_item(FUNC_POP, -1);
        send_item(FUNC_POP, '0);
        send_item(FUNC_POP, INT_MIN);
    endtask

    task automatic test_full_stack();
        idle_pct = 9;
        send_item(FUNC_PUSH, INT_MAX);
        send_item(FUNC_PUSH, INT_MAX);
        send_item(FUNC_PUSH, 1);
        send_item(FUNC_PUSH, 32'sh5555_5555);
        send_item(FUNC_PUSH, 32'shAAAA_AAAA);
        send_item(FUNC_PUSH, INT_MIN);
        for (int i = 6; i < STACK_DEPTH; i++)
            send_item(FUNC_PUSH, $urandom);
        send_item(FUNC_PUSH, -1);
    endtask

    task automatic test_random_ops(input int n_items, input int pct);
        int push_pct;
        int burst;
        idle_pct = pct;
        burst    = 0;
        push_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            // bursts of push-heavy and pop-heavy items sweep between empty and full
            if (burst == 0)
            begin
                burst = $urandom_range(40, 4);
                case ($urandom_range(3))
                    0: push_pct = 20;
                    1: push_pct = 50;
                    2: push_pct = 80;
                    default: push_pct = 95;
                endcase
            end
            burst--;
            if ($urandom_range(99) < push_pct)
                send_item(FUNC_PUSH, pick_value());
            else
                send_item(FUNC_POP, pick_value());
        end
    endtask

    initial
    begin
        int guard;
        model_level = 0;
        model_min   = INT_MAX;
        model_max   = INT_MIN;
        model_sum   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_edges();
        test_full_stack();
        test_random_ops(500, 9);
        wait_drained();
        test_random_ops(500, 86);
        wait_drained();
        test_random_ops(500, 0);

        start <= 1'b0;
        guard = 0;
        while (expected_q.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (err_cnt == 0 && expected_q.size() == 0)
            $display("stack_with_min_max_sum verification clean");
        else
            $display("stack_with_min_max_sum verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/smms_pkg.sv
rtl/smms_ram.sv
rtl/smms_ctrl.sv
rtl/smms_dp.sv
rtl/stack_with_min_max_sum.sv
tb/tb_stack_with_min_max_sum.sv
